>>> hdl/pfoq_pkg.sv
// Package for the paced frame output queue: widths, item kinds, constants.
// Used by the input and result interfaces, controller, datapath and top level.
`default_nettype none
package pfoq_pkg;
  localparam int unsigned ByteDepthDefault  = 4096;
  localparam int unsigned FrameDepthDefault = 32;
  localparam int unsigned MaxResults        = 64;
  localparam int unsigned UnitsPerByte      = 1000;
  localparam int unsigned MaxElapsedMs      = 1000;
  localparam int unsigned CapScale          = 100;
  localparam int unsigned MaxFrameLen       = 16'hFFFF;

  typedef enum logic [2:0] {
    KIND_PUT   = 3'd0,
    KIND_DELAY = 3'd1,
    KIND_CLEAR = 3'd2,
    KIND_SKIP  = 3'd3,
    KIND_TICK  = 3'd4
  } kind_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic [15:0] delay_ms;
    logic [31:0] now_ms;
    logic [6:0]  sink_room;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       accepted;
    logic       last;
  } out_item_t;
endpackage
`default_nettype wire

>>> hdl/pfoq_in_if.sv
// Input item channel with valid/ready handshake.
// Depends on pfoq_pkg for the payload type.
`default_nettype none
interface pfoq_in_if;
  logic                valid;
  logic                ready;
  pfoq_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/pfoq_out_if.sv
// Result item channel with valid/ready handshake.
// Depends on pfoq_pkg for the payload type.
`default_nettype none
interface pfoq_out_if;
  logic                valid;
  logic                ready;
  pfoq_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/pfoq_cfg_if.sv
// Configuration write channel carrying chars_per_second.
// Standalone, no package dependency.
`default_nettype none
interface pfoq_cfg_if;
  logic        valid;
  logic        ready;
  logic [16:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/pfoq_ctrl.sv
// Controller state machine of the paced frame output queue.
// Depends on pfoq_pkg; drives datapath commands, reads datapath status.
`default_nettype none
module pfoq_ctrl (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire logic out_busy_i,
  input  wire logic [2:0] kind_i,
  input  wire logic st_frame_empty_i,
  input  wire logic st_len_nz_i,
  input  wire logic st_can_send_i,
  input  wire logic st_hold_nz_i,
  input  wire logic st_hold_wait_i,
  input  wire logic st_skip_done_i,
  output logic      cmd_load_o,
  output logic      cmd_exec_o,
  output logic      cmd_budget_o,
  output logic      cmd_rd_o,
  output logic      cmd_send_o,
  output logic      cmd_pop_o,
  output logic      cmd_hold_o,
  output logic      cmd_skip_o,
  output logic      cmd_finish_o
);
  import pfoq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_BUDGET, S_READ, S_DECIDE, S_SKIP, S_DONE
  } state_e;

  state_e state_q;

  assign in_ready_o = (state_q == S_IDLE);

  // Commands decode from state and status.
  always_comb begin
    cmd_load_o   = (state_q == S_IDLE) && in_valid_i;
    cmd_exec_o   = (state_q == S_EXEC);
    cmd_budget_o = (state_q == S_BUDGET);
    cmd_rd_o     = (state_q == S_READ);
    cmd_send_o   = (state_q == S_DECIDE) && !out_busy_i && !st_frame_empty_i && st_len_nz_i
                   && st_can_send_i;
    cmd_hold_o   = (state_q == S_DECIDE) && !st_frame_empty_i && !st_len_nz_i && st_hold_nz_i;
    cmd_pop_o    = (state_q == S_DECIDE) && !st_frame_empty_i && !st_len_nz_i
                   && !(st_hold_nz_i && st_hold_wait_i);
    cmd_skip_o   = (state_q == S_SKIP);
    cmd_finish_o = (state_q == S_DONE) && !out_busy_i;
  end

  // Hold state, step each item through its states, including a tick's drain loop.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE: if (in_valid_i) state_q <= S_EXEC;
        S_EXEC: begin
          if (kind_i == KIND_TICK) state_q <= S_BUDGET;
          else if (kind_i == KIND_SKIP) state_q <= S_SKIP;
          else state_q <= S_DONE;
        end
        S_BUDGET: state_q <= S_READ;
        S_READ: state_q <= S_DECIDE;
        S_DECIDE: begin
          if (st_frame_empty_i) state_q <= S_DONE;
          else if (st_len_nz_i) begin
            if (!st_can_send_i) state_q <= S_DONE;
            else if (!out_busy_i) state_q <= S_READ;
          end else if (st_hold_nz_i && st_hold_wait_i) state_q <= S_DONE;
          else state_q <= S_READ;
        end
        S_SKIP: if (st_skip_done_i) state_q <= S_DONE;
        S_DONE: if (!out_busy_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_send_only_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_send_o |-> state_q == S_DECIDE) else $error("send outside decide");
  a_load_then_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_load_o |=> state_q == S_EXEC) else $error("load did not enter exec");
  a_finish_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_finish_o |=> in_ready_o) else $error("finish did not return idle");
`endif
endmodule
`default_nettype wire

>>> hdl/pfoq_dp.sv
// Datapath of the paced frame output queue: rings, pointers, bucket, result register.
// Depends on pfoq_pkg; driven by pfoq_ctrl commands.
`default_nettype none
module pfoq_dp #(
  parameter int unsigned BYTE_DEPTH  = pfoq_pkg::ByteDepthDefault,
  parameter int unsigned FRAME_DEPTH = pfoq_pkg::FrameDepthDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire pfoq_pkg::in_item_t in_data_i,
  input  wire logic cfg_valid_i,
  input  wire logic [16:0] cfg_data_i,
  input  wire logic out_ready_i,
  output logic out_valid_o,
  output pfoq_pkg::out_item_t out_data_o,
  output logic out_busy_o,
  output logic [2:0] kind_o,
  output logic st_frame_empty_o,
  output logic st_len_nz_o,
  output logic st_can_send_o,
  output logic st_hold_nz_o,
  output logic st_hold_wait_o,
  output logic st_skip_done_o,
  input  wire logic cmd_load_i,
  input  wire logic cmd_exec_i,
  input  wire logic cmd_budget_i,
  input  wire logic cmd_rd_i,
  input  wire logic cmd_send_i,
  input  wire logic cmd_pop_i,
  input  wire logic cmd_hold_i,
  input  wire logic cmd_skip_i,
  input  wire logic cmd_finish_i
);
  import pfoq_pkg::*;

  localparam int unsigned BW = $clog2(BYTE_DEPTH);
  localparam int unsigned CW = $clog2(BYTE_DEPTH + 1);
  localparam int unsigned FW = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
  localparam int unsigned NW = $clog2(FRAME_DEPTH + 1);

  // Memories.
  logic [7:0]  byte_mem [BYTE_DEPTH];
  logic [15:0] len_mem  [FRAME_DEPTH];
  logic [15:0] hold_mem [FRAME_DEPTH];

  in_item_t    item_q;
  logic [16:0] cps_q;
  logic [BW-1:0] byte_head_q;
  logic [CW-1:0] byte_count_q;
  logic [FW-1:0] frame_head_q;
  logic [NW-1:0] frame_count_q;
  logic          hold_active_q;
  logic [31:0]   hold_end_q, prev_time_q, budget_q;
  logic [6:0]    sent_q;
  logic          acc_q;
  logic [NW-1:0] skip_idx_q;
  logic [7:0]    rd_byte_q;
  logic [7:0]    pend_byte_q;
  logic [15:0]   rd_len_q, rd_hold_q, tail_len_q, tail_hold_q;
  logic          out_valid_q;
  out_item_t     out_q;

  // Ring index helpers.
  function automatic logic [FW-1:0] fwrap(input logic [FW:0] v);
    logic [FW:0] d;
    d = FRAME_DEPTH[FW:0];
    return (v >= d) ? FW'(v - d) : v[FW-1:0];
  endfunction
  function automatic logic [BW-1:0] bwrap(input logic [BW:0] v);
    logic [BW:0] d;
    d = BYTE_DEPTH[BW:0];
    return (v >= d) ? BW'(v - d) : v[BW-1:0];
  endfunction

  // Wrap-safe check that the hold ending at e is still running.
  function automatic logic hold_end_q_wait(input logic [31:0] e);
    logic [31:0] diff;
    diff = item_q.now_ms - e;
    return diff[31];
  endfunction

  logic [FW-1:0] tail_slot, new_slot, skip_slot, head_next;
  logic [BW-1:0] wr_pos, byte_head_next;
  logic          frames_full, bytes_full, need_new;
  logic [6:0]    room;
  logic          hold_wait;
  logic [31:0]   dt, dtc;
  logic [33:0]   cap, bud;
  logic [49:0]   cap_full;
  logic [49:0]   add_full;

  assign tail_slot = fwrap({1'b0, frame_head_q} + FW'(frame_count_q - NW'(1)));
  assign new_slot  = fwrap({1'b0, frame_head_q} + FW'(frame_count_q));
  assign skip_slot = fwrap({1'b0, frame_head_q} + FW'(skip_idx_q));
  assign head_next = fwrap({1'b0, frame_head_q} + (FW+1)'(1));
  assign wr_pos    = bwrap({1'b0, byte_head_q} + BW'(byte_count_q));
  assign byte_head_next = bwrap({1'b0, byte_head_q} + (BW+1)'(1));
  assign frames_full = (frame_count_q >= NW'(FRAME_DEPTH));
  assign bytes_full  = (byte_count_q >= CW'(BYTE_DEPTH));
  assign need_new = (frame_count_q == '0) || (tail_hold_q != '0)
                    || (tail_len_q >= 16'(MaxFrameLen));
  assign room = (item_q.sink_room > 7'(MaxResults)) ? 7'(MaxResults) : item_q.sink_room;

  // Token bucket refill terms.
  assign dt  = item_q.now_ms - prev_time_q;
  assign dtc = (dt > 32'(MaxElapsedMs)) ? 32'(MaxElapsedMs) : dt;
  assign cap_full = 50'(cps_q) * 50'(CapScale);
  assign cap = (cap_full < 50'(UnitsPerByte)) ? 34'(UnitsPerByte) : cap_full[33:0];
  assign add_full = 50'(budget_q) + 50'(dtc[9:0]) * 50'(cps_q);
  assign bud = (add_full > 50'(cap)) ? cap : add_full[33:0];

  assign hold_wait = hold_active_q ? hold_end_q_wait(hold_end_q)
                                   : hold_end_q_wait(item_q.now_ms + 32'(rd_hold_q));

  assign kind_o           = item_q.kind;
  assign st_frame_empty_o = (frame_count_q == '0);
  assign st_len_nz_o      = (rd_len_q != '0);
  assign st_can_send_o    = !((cps_q != '0) && (budget_q < 32'(UnitsPerByte)))
                            && (sent_q < room);
  assign st_hold_nz_o     = (rd_hold_q != '0);
  assign st_hold_wait_o   = hold_wait;
  assign st_skip_done_o   = (skip_idx_q >= frame_count_q);
  assign out_busy_o       = out_valid_q && !out_ready_i;
  assign out_valid_o      = out_valid_q;
  assign out_data_o       = out_q;

  // Memory writes and registered reads.
  always_ff @(posedge clk_i) begin
    if (cmd_exec_i && item_q.kind == KIND_PUT && !bytes_full && !(need_new && frames_full)) begin
      byte_mem[wr_pos] <= item_q.data_byte;
    end
    if (cmd_rd_i) rd_byte_q <= byte_mem[byte_head_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_exec_i && item_q.kind == KIND_PUT && !bytes_full && !(need_new && frames_full)) begin
      len_mem[need_new ? new_slot : tail_slot] <= need_new ? 16'd1 : tail_len_q + 16'd1;
      if (need_new) hold_mem[new_slot] <= '0;
    end else if (cmd_exec_i && item_q.kind == KIND_DELAY && item_q.delay_ms != '0) begin
      if ((frame_count_q == '0) || (tail_hold_q != '0)) begin
        if (!frames_full) begin
          len_mem[new_slot]  <= '0;
          hold_mem[new_slot] <= item_q.delay_ms;
        end
      end else begin
        hold_mem[tail_slot] <= item_q.delay_ms;
      end
    end else if (cmd_send_i) begin
      len_mem[frame_head_q] <= rd_len_q - 16'd1;
    end else if (cmd_skip_i && !st_skip_done_o) begin
      hold_mem[skip_slot] <= '0;
    end
    if (cmd_load_i || cmd_budget_i) begin
      tail_len_q  <= len_mem[tail_slot];
      tail_hold_q <= hold_mem[tail_slot];
    end
    if (cmd_rd_i) begin
      rd_len_q  <= len_mem[frame_head_q];
      rd_hold_q <= hold_mem[frame_head_q];
    end
  end

  // Hold the item, advance pointers, drive results.
  // A sent byte waits in pend_byte_q until the next send or the finish,
  // so the final byte of a tick goes out once, with last set.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cps_q <= '0; byte_head_q <= '0; byte_count_q <= '0;
      frame_head_q <= '0; frame_count_q <= '0; hold_active_q <= 1'b0;
      hold_end_q <= '0; prev_time_q <= '0; budget_q <= '0;
      sent_q <= '0; acc_q <= 1'b0; skip_idx_q <= '0; out_valid_q <= 1'b0;
      item_q <= '0; out_q <= '0; pend_byte_q <= '0;
    end else begin
      if (cfg_valid_i) cps_q <= cfg_data_i;
      if (cmd_finish_i || (cmd_send_i && sent_q != '0)) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (cmd_load_i) begin
        item_q <= in_data_i; sent_q <= '0; acc_q <= 1'b0; skip_idx_q <= '0;
      end
      if (cmd_exec_i) begin
        unique case (item_q.kind)
          KIND_PUT: if (!bytes_full && !(need_new && frames_full)) begin
            acc_q <= 1'b1;
            byte_count_q <= byte_count_q + CW'(1);
            if (need_new) frame_count_q <= frame_count_q + NW'(1);
          end
          KIND_DELAY: if (item_q.delay_ms != '0 && ((frame_count_q == '0)
                          || (tail_hold_q != '0)) && !frames_full) begin
            frame_count_q <= frame_count_q + NW'(1);
          end
          KIND_CLEAR: begin
            byte_head_q <= '0; byte_count_q <= '0; frame_head_q <= '0;
            frame_count_q <= '0; hold_active_q <= 1'b0;
          end
          KIND_SKIP: hold_active_q <= 1'b0;
          default: ;
        endcase
      end
      if (cmd_budget_i) begin
        if (cps_q != '0) budget_q <= bud[31:0];
        prev_time_q <= item_q.now_ms;
      end
      if (cmd_skip_i && !st_skip_done_o) skip_idx_q <= skip_idx_q + NW'(1);
      if (cmd_send_i) begin
        if (sent_q != '0) begin
          out_q <= '{out_byte: pend_byte_q, byte_valid: 1'b1, accepted: 1'b0, last: 1'b0};
        end
        pend_byte_q <= rd_byte_q;
        sent_q <= sent_q + 7'd1;
        byte_head_q <= byte_head_next;
        byte_count_q <= byte_count_q - CW'(1);
        if (cps_q != '0) budget_q <= budget_q - 32'(UnitsPerByte);
      end
      if (cmd_hold_i) begin
        if (!hold_active_q) hold_end_q <= item_q.now_ms + 32'(rd_hold_q);
        hold_active_q <= hold_wait;
      end
      if (cmd_pop_i) begin
        frame_head_q  <= head_next;
        frame_count_q <= frame_count_q - NW'(1);
        if (frame_count_q == NW'(1)) byte_head_q <= '0;
      end
      if (cmd_finish_i) begin
        if (item_q.kind == KIND_TICK && frame_count_q == '0) byte_head_q <= '0;
        if (item_q.kind == KIND_TICK && sent_q != '0) begin
          out_q <= '{out_byte: pend_byte_q, byte_valid: 1'b1, accepted: 1'b0, last: 1'b1};
        end else begin
          out_q <= '{out_byte: 8'd0, byte_valid: 1'b0, accepted: acc_q, last: 1'b1};
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> hdl/paced_frame_output_queue.sv
// Paced frame output queue top level: controller plus datapath.
// Put/delay/clear: load, execute, then the finish state registers the result; idle takes the next item.
// Skip: clears the hold of each queued frame in turn. Tick: refills the bucket, then loops read/decide
// for each sent byte or passed frame; output stalls hold the loop. One item is in flight at a time.
// Each sent byte waits one step in a register so the final one carries last.
// Reset (rst_ni low, async) empties both rings, zeroes the bucket, time and rate register.
`default_nettype none
module paced_frame_output_queue #(
  parameter int unsigned BYTE_DEPTH  = pfoq_pkg::ByteDepthDefault,
  parameter int unsigned FRAME_DEPTH = pfoq_pkg::FrameDepthDefault
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  pfoq_in_if.sink    in_ch,
  pfoq_out_if.source out_ch,
  pfoq_cfg_if.sink   cfg_ch
);
  import pfoq_pkg::*;

  logic busy, load, exe, budg, rd, snd, pop, hld, skp, fin;
  logic fe, lnz, cs, hnz, hw, sd;
  logic [2:0] kind;

  assign cfg_ch.ready = 1'b1;

  pfoq_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(in_ch.valid), .in_ready_o(in_ch.ready),
    .out_busy_i(busy), .kind_i(kind), .st_frame_empty_i(fe), .st_len_nz_i(lnz),
    .st_can_send_i(cs), .st_hold_nz_i(hnz), .st_hold_wait_i(hw), .st_skip_done_i(sd),
    .cmd_load_o(load), .cmd_exec_o(exe), .cmd_budget_o(budg), .cmd_rd_o(rd),
    .cmd_send_o(snd), .cmd_pop_o(pop), .cmd_hold_o(hld), .cmd_skip_o(skp),
    .cmd_finish_o(fin)
  );

  pfoq_dp #(.BYTE_DEPTH(BYTE_DEPTH), .FRAME_DEPTH(FRAME_DEPTH)) u_dp (
    .clk_i, .rst_ni, .in_data_i(in_ch.data), .cfg_valid_i(cfg_ch.valid),
    .cfg_data_i(cfg_ch.data), .out_ready_i(out_ch.ready), .out_valid_o(out_ch.valid),
    .out_data_o(out_ch.data), .out_busy_o(busy), .kind_o(kind), .st_frame_empty_o(fe),
    .st_len_nz_o(lnz), .st_can_send_o(cs), .st_hold_nz_o(hnz), .st_hold_wait_o(hw),
    .st_skip_done_o(sd), .cmd_load_i(load), .cmd_exec_i(exe), .cmd_budget_i(budg),
    .cmd_rd_i(rd), .cmd_send_i(snd), .cmd_pop_i(pop), .cmd_hold_i(hld),
    .cmd_skip_i(skp), .cmd_finish_i(fin)
  );
endmodule
`default_nettype wire

>>> dv/tb_paced_frame_output_queue.sv
// Testbench for paced_frame_output_queue: drives put/delay/clear/skip/tick items,
// predicts result items with a queue model and checks them in order.
// Depends on pfoq_pkg, pfoq_in_if, pfoq_out_if, pfoq_cfg_if and the RTL.
`timescale 1ns / 1ps
module tb_paced_frame_output_queue;
  import pfoq_pkg::*;

  localparam int unsigned BDEPTH = 4096;
  localparam int unsigned FDEPTH = 32;
  localparam longint unsigned CYCLE_LIMIT = 2_000_000;

  // Model of the queue; computes expected result items per input item.
  class pacing_scoreboard;
    logic [7:0]  bytes[BDEPTH];
    logic [15:0] flen[FDEPTH];
    logic [15:0] fhold[FDEPTH];
    int unsigned bhead, bcount, fhead, fcount;
    bit          holding;
    logic [31:0] hold_end, last_tick, budget, cps;
    out_item_t   pending[$];

    function void clear_state();
      bhead = 0; bcount = 0; fhead = 0; fcount = 0;
      holding = 0; hold_end = 0; last_tick = 0; budget = 0; cps = 0;
    endfunction

    function int unsigned tail();
      return (fhead + fcount - 1) % FDEPTH;
    endfunction

    function bit open_frame();
      int unsigned s;
      if (fcount >= FDEPTH) return 0;
      s = (fhead + fcount) % FDEPTH;
      flen[s] = 0; fhold[s] = 0; fcount++;
      return 1;
    endfunction

    function void push(logic [7:0] b, bit v, bit acc, bit lst);
      out_item_t r;
      r.out_byte = b; r.byte_valid = v; r.accepted = acc; r.last = lst;
      pending.push_back(r);
    endfunction

    function void tick(logic [31:0] now, int unsigned room);
      int n;
      int unsigned f;
      logic [31:0] dt;
      longint unsigned cap, bud;
      n = 0;
      if (room > MaxResults) room = MaxResults;
      if (cps != 0) begin
        dt = now - last_tick;
        if (dt > 1000) dt = 1000;
        cap = longint'(cps) * 100;
        if (cap < 1000) cap = 1000;
        bud = longint'(budget) + longint'(dt) * cps;
        if (bud > cap) bud = cap;
        budget = bud[31:0];
      end
      last_tick = now;
      while (fcount != 0) begin
        f = fhead;
        if (flen[f] != 0) begin
          if (cps != 0 && budget < 1000) break;
          if (n >= room) break;
          push(bytes[bhead], 1, 0, 0);
          n++;
          bhead = (bhead + 1) % BDEPTH;
          bcount--;
          flen[f]--;
          if (cps != 0) budget -= 1000;
          continue;
        end
        if (fhold[f] != 0) begin
          if (!holding) begin
            holding = 1;
            hold_end = now + fhold[f];
          end
          dt = now - hold_end;
          if (dt[31]) break;
          holding = 0;
        end
        fhead = (fhead + 1) % FDEPTH;
        fcount--;
      end
      if (fcount == 0) bhead = 0;
      if (n == 0) push(0, 0, 0, 1);
      else pending[$].last = 1;
    endfunction

    // Note an accepted input item and queue its expected results.
    function void note_input(in_item_t it);
      bit acc;
      acc = 0;
      case (it.kind)
        KIND_PUT: begin
          if (bcount < BDEPTH) begin
            acc = 1;
            if (fcount == 0 || fhold[tail()] != 0 || flen[tail()] >= MaxFrameLen)
              acc = open_frame();
            if (acc) begin
              bytes[(bhead + bcount) % BDEPTH] = it.data_byte;
              bcount++;
              flen[tail()]++;
            end
          end
        end
        KIND_DELAY: begin
          if (it.delay_ms != 0) begin
            if (fcount != 0 && fhold[tail()] == 0) fhold[tail()] = it.delay_ms;
            else if (open_frame()) fhold[tail()] = it.delay_ms;
          end
        end
        KIND_CLEAR: begin
          bhead = 0; bcount = 0; fhead = 0; fcount = 0; holding = 0;
        end
        KIND_SKIP: begin
          for (int unsigned i = 0; i < fcount; i++) fhold[(fhead + i) % FDEPTH] = 0;
          holding = 0;
        end
        KIND_TICK: begin
          tick(it.now_ms, it.sink_room);
          return;
        end
        default: ;
      endcase
      push(0, 0, acc, 1);
    endfunction

    // Compare one result item with the oldest expectation.
    function bit check_result(out_item_t got, output string msg);
      out_item_t e;
      if (pending.size() == 0) begin
        msg = $sformatf("unexpected result %p", got);
        return 0;
      end
      e = pending.pop_front();
      if (got !== e) begin
        msg = $sformatf("result %p, expected %p", got, e);
        return 0;
      end
      return 1;
    endfunction
  endclass

  logic clk_i, rst_ni;
  pfoq_in_if  in_ch();
  pfoq_out_if out_ch();
  pfoq_cfg_if cfg_ch();

  paced_frame_output_queue uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  pacing_scoreboard sb;
  int mismatches;
  longint unsigned cycles;
  logic [31:0] clock_ms;
  int burst_left;

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic report(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Sample and check results at each rising edge; count cycles for the timeout.
  always @(posedge clk_i) begin
    string msg;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("paced_frame_output_queue verification failed");
      $finish;
    end
    if (rst_ni && out_ch.valid && out_ch.ready)
      if (!sb.check_result(out_ch.data, msg)) report(msg);
  end

  // Stall the receiver on its own pattern: quiet stretches and busy stretches.
  always @(negedge clk_i) begin
    if (!rst_ni) out_ch.ready <= 1'b1;
    else if ((cycles / 300) % 3 == 0) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(0, 3) != 0);
  end

  // Send one item, honoring burst gaps; hold valid until accepted.
  // Valid stays high on return so a following item can go out back to back.
  task automatic send(in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.data  <= it;
    in_ch.valid <= 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_input(it);
    @(negedge clk_i);
  endtask

  task automatic send_kind(kind_e k, logic [7:0] b, logic [15:0] d, logic [31:0] t,
                           logic [6:0] room);
    in_item_t it;
    it.kind = k; it.data_byte = b; it.delay_ms = d; it.now_ms = t; it.sink_room = room;
    send(it);
  endtask

  // Drop valid, wait until every expected result has come, plus settle time.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (150) @(negedge clk_i);
  endtask

  task automatic write_rate(logic [16:0] rate);
    drain();
    cfg_ch.data  <= rate;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ch.ready);
    sb.cps = rate;
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  // Random item: mostly frames of bytes with holds, ticks advancing time.
  task automatic random_item();
    in_item_t it;
    int sel;
    sel = $urandom_range(0, 99);
    it.data_byte = 8'($urandom);
    it.delay_ms  = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 40));
    it.sink_room = $urandom_range(0, 9) == 0 ? 7'($urandom) : 7'($urandom_range(0, 64));
    clock_ms += $urandom_range(0, 5) == 0 ? $urandom : $urandom_range(0, 60);
    it.now_ms = clock_ms;
    if (sel < 50) it.kind = KIND_PUT;
    else if (sel < 60) it.kind = KIND_DELAY;
    else if (sel < 62) it.kind = KIND_CLEAR;
    else if (sel < 65) it.kind = KIND_SKIP;
    else if (sel < 97) it.kind = KIND_TICK;
    else it.kind = 3'($urandom_range(5, 7));
    send(it);
  endtask

  initial begin
    sb = new();
    sb.clear_state();
    mismatches = 0; cycles = 0; burst_left = 0; clock_ms = 0;
    in_ch.valid = 0; in_ch.data = '0;
    cfg_ch.valid = 0; cfg_ch.data = '0;
    rst_ni = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // Directed: extremes, each kind, zero hold, unknown kinds, oversize room.
    send_kind(KIND_TICK, 0, 0, 0, 0);
    send_kind(KIND_PUT, 8'h00, 0, 0, 0);
    send_kind(KIND_PUT, 8'hFF, 0, 0, 0);
    send_kind(KIND_DELAY, 0, 16'h0000, 0, 0);
    send_kind(KIND_DELAY, 0, 16'd5, 0, 0);
    send_kind(KIND_DELAY, 0, 16'hFFFF, 0, 0);
    send_kind(KIND_PUT, 8'hA5, 0, 0, 0);
    send_kind(KIND_TICK, 0, 0, 32'd1, 7'd127);
    send_kind(KIND_TICK, 0, 0, 32'd10, 7'd64);
    send_kind(KIND_SKIP, 0, 0, 0, 0);
    send_kind(KIND_TICK, 0, 0, 32'hFFFF_FFF0, 7'd1);
    send_kind(KIND_TICK, 0, 0, 32'h0000_0010, 7'd64);
    send_kind(kind_e'(3'd5), 8'h5A, 16'hFFFF, 32'hFFFF_FFFF, 7'h7F);
    send_kind(kind_e'(3'd7), 0, 0, 0, 0);
    // Fill the frame ring with holds, then overflow it.
    for (int i = 0; i < 34; i++) send_kind(KIND_DELAY, 0, 16'd1, 0, 0);
    send_kind(KIND_PUT, 8'h11, 0, 0, 0);
    send_kind(KIND_CLEAR, 0, 0, 0, 0);
    send_kind(KIND_TICK, 0, 0, 32'hFFFF_FFFF, 7'd64);
    drain();

    // Random phases across rate settings, extremes included.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_rate(17'd0);
        1: write_rate(17'd1);
        2: write_rate(17'd100000);
        3: write_rate(17'h1FFFF);
        default: write_rate(17'($urandom_range(5, 5000)));
      endcase
      for (int i = 0; i < 52; i++) random_item();
      drain();
    end
    write_rate(17'd0);

    drain();
    if (mismatches == 0) $display("paced_frame_output_queue verification clean");
    else $display("paced_frame_output_queue verification failed");
    $finish;
  end
endmodule
